@@ design/udec_pkg.sv @@
// ============================================================================
// udec_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ============================================================================
package udec_pkg;

  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_ZERO    = 8'h00;

  // Depth of the job queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Escape tracking: nothing pending, percent held, percent and a digit held.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } udec_phase_e;

  // One classified input byte: up to three output bytes in order.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } udec_job_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

@@ design/udec_in_if.sv @@
// ============================================================================
// udec_in_if
// Encoded byte channel: valid/ready handshake with byte and end-of-string.
// ============================================================================
interface udec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ design/udec_out_if.sv @@
// ============================================================================
// udec_out_if
// Decoded byte channel: valid/ready handshake with byte and end-of-string.
// ============================================================================
interface udec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ design/url_percent_decoder.sv @@
// ============================================================================
// url_percent_decoder
// Streaming URL percent decoder: %XX to a byte, plus to space, rest as is.
// ============================================================================
// Usage. Encoded text enters on in_i one byte per beat, with in_last set on
// the final byte of each string. Decoded bytes leave on out_o, with out_last
// set on the final decoded byte of the string. Both channels use valid/ready.
// A percent sign not followed by two hex digits comes out literally and the
// bytes after it are decoded afresh; an escape cut short by the end of the
// string is flushed literally, so every string ends with an out_last beat.
// Throughput: one input byte per cycle while the job queue has room. Each
// byte becomes a job of zero to three output bytes; non-empty jobs wait in a
// four-entry queue. The back end sends one byte per cycle while the receiver
// is ready, so a byte that breaks an escape yields up to three output beats.
// Each result passes through the job queue and then the output register.
// in_i.ready falls only when the job queue is full, so a stalled receiver
// holds its beat in the output register and backs up through the queue.
// Reset (rst_ni low, asynchronous) clears the escape state, the queue and the
// output valid flag; no output is pending after reset.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  udec_in_if.sink    in_i,
  udec_out_if.source out_o
);

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  udec_pkg::udec_job_t job;
  udec_pkg::udec_job_t head;

  // Front end: classification and escape tracking.
  udec_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  // Decoupling queue.
  udec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // Back end: serialises each job into output beats.
  udec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ design/udec_front.sv @@
// ============================================================================
// udec_front
// Accepts encoded bytes, tracks escape state and builds one output job each.
// ============================================================================
module udec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  udec_in_if.sink              in_i,
  input  logic                 full_i,
  output logic                 push_o,
  output udec_pkg::udec_job_t  job_o
);

  udec_pkg::udec_phase_e phase_q, phase_d;
  logic [7:0]            held_q, held_d;
  logic                  accept;
  logic                  b_hex;
  logic                  idle_emit;
  logic                  idle_hold;
  logic [7:0]            idle_byte;
  logic [7:0]            b;
  logic                  lst;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign b          = in_i.in_byte;
  assign lst        = in_i.in_last;
  assign b_hex      = udec_pkg::is_hex(b);

  // What the byte does on its own when nothing is pending.
  always_comb begin
    idle_hold = 1'b0;
    idle_emit = 1'b1;
    idle_byte = b;
    if (b == udec_pkg::CHR_PERCENT) begin
      idle_hold = ~lst;
      idle_emit = lst;
    end else if (b == udec_pkg::CHR_PLUS) begin
      idle_byte = udec_pkg::CHR_SPACE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= udec_pkg::PH_IDLE;
      held_q  <= udec_pkg::CHR_ZERO;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    held_d        = held_q;
    job_o.cnt     = 2'd0;
    job_o.last    = lst;
    job_o.bytes   = '0;
    if (accept) begin
      phase_d = idle_hold ? udec_pkg::PH_PCT : udec_pkg::PH_IDLE;
      case (phase_q)
        udec_pkg::PH_PCT: begin
          if (b_hex) begin
            if (lst) begin
              job_o.cnt      = 2'd2;
              job_o.bytes[0] = udec_pkg::CHR_PERCENT;
              job_o.bytes[1] = b;
              phase_d        = udec_pkg::PH_IDLE;
            end else begin
              held_d  = b;
              phase_d = udec_pkg::PH_DIGIT;
            end
          end else begin
            job_o.cnt      = idle_emit ? 2'd2 : 2'd1;
            job_o.bytes[0] = udec_pkg::CHR_PERCENT;
            job_o.bytes[1] = idle_byte;
          end
        end
        udec_pkg::PH_DIGIT: begin
          if (b_hex) begin
            job_o.cnt      = 2'd1;
            job_o.bytes[0] = {udec_pkg::hex_value(held_q), udec_pkg::hex_value(b)};
            phase_d        = udec_pkg::PH_IDLE;
          end else begin
            job_o.cnt      = idle_emit ? 2'd3 : 2'd2;
            job_o.bytes[0] = udec_pkg::CHR_PERCENT;
            job_o.bytes[1] = held_q;
            job_o.bytes[2] = idle_byte;
          end
        end
        default: begin
          job_o.cnt      = idle_emit ? 2'd1 : 2'd0;
          job_o.bytes[0] = idle_byte;
        end
      endcase
      if (lst) begin
        phase_d = udec_pkg::PH_IDLE;
        held_d  = udec_pkg::CHR_ZERO;
      end
    end
  end

  assign push_o = accept & (job_o.cnt != 2'd0);

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && lst |-> push_o)
    else $error("end of string produced no output");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && lst |=> phase_q == udec_pkg::PH_IDLE && held_q == udec_pkg::CHR_ZERO)
    else $error("escape state not cleared at end of string");

  a_digit_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == udec_pkg::PH_DIGIT |-> udec_pkg::is_hex(held_q))
    else $error("held digit is not a hex character");

endmodule

@@ design/udec_fifo.sv @@
// ============================================================================
// udec_fifo
// Short queue of decode jobs between the front and the back.
// ============================================================================
module udec_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  udec_pkg::udec_job_t  job_i,
  input  logic                 pop_i,
  output udec_pkg::udec_job_t  head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  udec_pkg::udec_job_t                        mem_q [udec_pkg::QueueDepth];
  logic [udec_pkg::QueuePtrW-1:0]             wr_q, wr_d, rd_q, rd_d;
  logic [udec_pkg::QueueCntW-1:0]             cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == udec_pkg::QueueCntW'(udec_pkg::QueueDepth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue underflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= udec_pkg::QueueCntW'(udec_pkg::QueueDepth))
    else $error("job queue count out of range");

endmodule

@@ design/udec_back.sv @@
// ============================================================================
// udec_back
// Unpacks queued jobs into single decoded beats through an output register.
// ============================================================================
module udec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  udec_pkg::udec_job_t  head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  udec_out_if.source           out_o
);

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       ol_q, ol_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       final_byte;

  assign load       = ~empty_i & (~ov_q | out_o.ready);
  assign final_byte = (idx_q == head_i.cnt - 2'd1);
  assign pop_o      = load & final_byte;

  always_comb begin
    ov_d  = ov_q & ~out_o.ready;
    ob_d  = ob_q;
    ol_d  = ol_q;
    idx_d = idx_q;
    if (load) begin
      ov_d  = 1'b1;
      ob_d  = head_i.bytes[idx_q];
      ol_d  = head_i.last & final_byte;
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      ov_q  <= ov_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.out_last = ol_q;

endmodule

@@ tb/sv/url_percent_decoder_chk.sv @@
`timescale 1ns / 1ps
// ============================================================================
// url_percent_decoder_chk
// Watches both channels, predicts each decoded beat and compares it in order.
// ============================================================================
module url_percent_decoder_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  udec_in_if          in_mon_i,
  udec_out_if         out_mon_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);

  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_F = 8'h46;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_F = 8'h66;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_beat_t;

  dec_beat_t             decoded_q[$];
  udec_pkg::udec_phase_e esc_phase  = udec_pkg::PH_IDLE;
  logic [7:0]            held_digit = 8'h00;
  int unsigned           err_cnt    = 0;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CHR_UPPER_A && c <= CHR_UPPER_F) ||
                 (c >= CHR_LOWER_A && c <= CHR_LOWER_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  task automatic emit_beat(input logic [7:0] d, input logic l);
    dec_beat_t e;
    e.data = d;
    e.last = l;
    decoded_q = {decoded_q, e};
  endtask

  // A byte seen with no escape pending.
  task automatic decode_plain(input logic [7:0] b, input logic l);
    if (b == udec_pkg::CHR_PERCENT) begin
      if (l) begin
        emit_beat(udec_pkg::CHR_PERCENT, 1'b1);
      end else begin
        esc_phase = udec_pkg::PH_PCT;
      end
    end else if (b == udec_pkg::CHR_PLUS) begin
      emit_beat(udec_pkg::CHR_SPACE, l);
    end else begin
      emit_beat(b, l);
    end
  endtask

  task automatic decode_step(input logic [7:0] b, input logic l);
    udec_pkg::udec_phase_e was;
    logic [4:0]            hi;
    logic [4:0]            lo;
    was       = esc_phase;
    esc_phase = udec_pkg::PH_IDLE;
    lo        = hex_digit(b);
    case (was)
      udec_pkg::PH_PCT: begin
        if (lo[4]) begin
          if (l) begin
            emit_beat(udec_pkg::CHR_PERCENT, 1'b0);
            emit_beat(b, 1'b1);
          end else begin
            held_digit = b;
            esc_phase  = udec_pkg::PH_DIGIT;
          end
        end else begin
          emit_beat(udec_pkg::CHR_PERCENT, 1'b0);
          decode_plain(b, l);
        end
      end
      udec_pkg::PH_DIGIT: begin
        hi = hex_digit(held_digit);
        if (lo[4]) begin
          emit_beat({hi[3:0], lo[3:0]}, l);
        end else begin
          emit_beat(udec_pkg::CHR_PERCENT, 1'b0);
          emit_beat(held_digit, 1'b0);
          decode_plain(b, l);
        end
      end
      default: begin
        decode_plain(b, l);
      end
    endcase
    if (l) begin
      esc_phase  = udec_pkg::PH_IDLE;
      held_digit = 8'h00;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_beat_t want;
    if (!rst_ni) begin
      decoded_q.delete();
      esc_phase  = udec_pkg::PH_IDLE;
      held_digit = 8'h00;
      pending_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        decode_step(in_mon_i.in_byte, in_mon_i.in_last);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat: expected none, actual byte %02h last %0b",
                   $realtime, out_mon_i.out_byte, out_mon_i.out_last);
        end else begin
          want = decoded_q.pop_front();
          if (want.data !== out_mon_i.out_byte) begin
            err_cnt++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $realtime, want.data, out_mon_i.out_byte);
          end
          if (want.last !== out_mon_i.out_last) begin
            err_cnt++;
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     $realtime, want.last, out_mon_i.out_last);
          end
        end
      end
      pending_o <= decoded_q.size();
    end
    err_cnt_o <= err_cnt;
  end

endmodule

@@ tb/sv/url_percent_decoder_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// url_percent_decoder_tb
// Feeds encoded strings into the decoder under random flow control; a checker
// beside the block predicts every decoded beat and this top gives the verdict.
// ============================================================================
module url_percent_decoder_tb;

  // Cycles without a single beat on either channel before the run is abandoned.
  // The longest legitimate silence is the deliberate receiver hold-off below.
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DirectedItems = 25;
  localparam int unsigned RandomItems   = 255;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  udec_in_if  in_if ();
  udec_out_if out_if ();

  int unsigned err_cnt;
  int unsigned pending;

  // Sender bookkeeping: beats accepted so far, beats left in the current burst,
  // and whether valid is currently being driven high.
  int unsigned sent_cnt   = 0;
  int unsigned burst_left = 0;
  bit          offer_on   = 1'b0;
  // Bumped by the sender to ask the receiver for one long hold-off.
  int unsigned hold_tok   = 0;

  logic [7:0]  text_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  url_percent_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  url_percent_decoder_chk u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_if),
    .out_mon_i (out_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // --------------------------------------------------------------------------
  // Sender helpers. Every call starts and ends just after a rising edge, so all
  // drives below are nonblocking and land after the edge has been sampled.
  // --------------------------------------------------------------------------

  // Valid only changes through here, which guarantees that it never receives two
  // nonblocking assignments within the same time step.
  task automatic set_offer(input bit v);
    if (offer_on != v) begin
      in_if.valid <= v;
      offer_on = v;
    end
  endtask

  // Between beats the sender either carries on with its burst or drops valid for
  // a short gap. While valid is low the payload is scrambled, so the block must
  // not take notice of anything that is not handshaken.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
                                                 $urandom_range(0, 8);
      set_offer(1'b0);
      in_if.in_byte <= 8'($urandom_range(0, 255));
      in_if.in_last <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offers one encoded byte until it is taken, then paces before returning.
  task automatic send_beat(input logic [7:0] b, input logic l);
    set_offer(1'b1);
    in_if.in_byte <= b;
    in_if.in_last <= l;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
    pace();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], i == s.len() - 1);
    end
  endtask

  // Stops offering and waits until the checker holds no outstanding beats.
  task automatic wait_drained();
    set_offer(1'b0);
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned k;
    logic [7:0]  c;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      c = 8'h30 + 8'(k);         // 0 to 9
    end else if (k < 16) begin
      c = 8'h41 + 8'(k - 10);    // A to F
    end else begin
      c = 8'h61 + 8'(k - 16);    // a to f
    end
    return c;
  endfunction

  // A byte that can never be a hex digit, picked so that it also exercises the
  // percent and plus paths when it breaks an escape.
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = 8'($urandom_range(8'h47, 8'h5A));   // G to Z
      1:       c = 8'($urandom_range(8'h67, 8'h7A));   // g to z
      2:       c = 8'($urandom_range(8'h80, 8'hFF));
      3:       c = udec_pkg::CHR_PERCENT;
      4:       c = udec_pkg::CHR_PLUS;
      default: c = 8'($urandom_range(8'h00, 8'h2F));
    endcase
    return c;
  endfunction

  // Appends one byte to the string being built.
  task automatic append_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  // Appends one lexical piece of encoded text. Most pieces are well formed
  // escapes or ordinary characters; the rest break escapes in every way.
  task automatic add_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      append_byte(udec_pkg::CHR_PERCENT);
      append_byte(hex_char());
      append_byte(hex_char());
    end else if (pick < 50) begin
      append_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 58) begin
      append_byte(udec_pkg::CHR_PLUS);
    end else if (pick < 72) begin
      append_byte(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      append_byte(udec_pkg::CHR_PERCENT);
      append_byte(odd_char());
    end else if (pick < 90) begin
      append_byte(udec_pkg::CHR_PERCENT);
      append_byte(hex_char());
      append_byte(odd_char());
    end else begin
      append_byte(udec_pkg::CHR_PERCENT);
    end
  endtask

  // Builds a string of random pieces. Now and then it is cut short at any byte,
  // which is how strings that end inside an escape come about.
  task automatic build_text();
    int unsigned pieces;
    int unsigned keep;
    text_q.delete();
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) :
                                           $urandom_range(1, 6);
    repeat (pieces) add_token();
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, text_q.size());
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict.
  // --------------------------------------------------------------------------
  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.in_last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings. A decoded zero must come out rather than end the string,
    // and the extreme digit values in mixed case must combine correctly.
    send_text("%00");
    send_text("%fF");
    // A lone plus that is also the last byte.
    send_text("+");
    // Raw zero and bytes above 127 pass straight through.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b1);
    // A percent broken by another percent, which then starts a good escape.
    send_text("%%41");
    // An escape broken after its first digit.
    send_text("%4x");
    // Strings that end straight after a percent and after one digit.
    send_text("%");
    send_text("%a");
    // A percent broken by a plus.
    send_text("%+");
    // Broken after one digit by a final percent: three bytes from one beat.
    send_text("%9%");
    wait_drained();

    // Random strings until the random budget is used up.
    while (sent_cnt < DirectedItems + RandomItems) begin
      build_text();
      for (int i = 0; i < text_q.size(); i++) begin
        send_beat(text_q[i], i == text_q.size() - 1);
      end
      // Once, the receiver goes quiet for a long stretch while beats keep coming,
      // so the internal queue fills and the input side has to stall.
      if (!hold_done && sent_cnt >= DirectedItems + 60) begin
        hold_tok++;
        hold_done = 1'b1;
      end
      // Once, the sender stops dead until everything owed has come out.
      if (!pause_done && sent_cnt >= DirectedItems + 180) begin
        wait_drained();
        pause_done = 1'b1;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("url_percent_decoder_tb: clean");
    end else begin
      $display("url_percent_decoder_tb: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. It cycles through flow-control styles of its own: always ready,
  // coin-toss, one beat in four, and a ragged on/off pattern. A request from the
  // sender turns into one long hold-off, counted here.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned seen_tok;
    int unsigned hold_left;
    int unsigned style;
    int unsigned style_left;
    int unsigned tick;
    seen_tok   = 0;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    tick       = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_tok != seen_tok) begin
        seen_tok  = hold_tok;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (tick % 4 == 0);
          default: out_if.ready <= (tick % 16 < 10);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long silence on both channels means a lost or stuck beat.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("url_percent_decoder_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
design/udec_pkg.sv
design/udec_in_if.sv
design/udec_out_if.sv
design/udec_front.sv
design/udec_fifo.sv
design/udec_back.sv
design/url_percent_decoder.sv
tb/sv/url_percent_decoder_chk.sv
tb/sv/url_percent_decoder_tb.sv
